// ===== sv/ccs_pkg.sv =====
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared constants, codes and types of the cable continuity scan block.
// ----------------------------------------------------------------------------
package ccs_pkg;

	// cable geometry
	localparam int PIN_COUNT     = 37;
	localparam int PINS_PER_MUX  = 8;
	localparam int SHORTS_STORED = 4;

	// field widths
	localparam int LEVEL_W  = 37;
	localparam int PIN_W    = 6;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 3;
	localparam int MUX_W    = 3;
	localparam int SLOTS    = 4;

	// command codes
	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK = 2'b01;

	typedef logic [PIN_W-1:0]   pin_t;
	typedef logic [LEVEL_W-1:0] level_t;

	// classification of one sample
	typedef struct packed {
		logic [STATUS_W-1:0]         status;
		logic [COUNT_W-1:0]          count;
		logic [SLOTS-1:0][PIN_W-1:0] shorts;
	} cls_t;

endpackage

// ===== sv/ccs_classify.sv =====
// ----------------------------------------------------------------------------
// ccs_classify
// Classifies the driven pin against the sampled levels and picks out the
// lowest shorted pins in ascending order.
// ----------------------------------------------------------------------------
module ccs_classify (
	input  ccs_pkg::pin_t   pin,
	input  ccs_pkg::level_t levels,
	output ccs_pkg::cls_t   cls
);
	import ccs_pkg::*;

	// index of the lowest set bit, with a found flag on top
	function automatic logic [PIN_W:0] lowest_set(input level_t m);
		logic [PIN_W:0] r;
		r = '0;
		for (int i = LEVEL_W - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = {1'b1, PIN_W'(i)};
			end
		end
		return r;
	endfunction

	level_t         live;
	level_t         other;
	logic           target_hi;
	level_t         masks [SLOTS+1];
	logic [PIN_W:0] hit   [SLOTS];
	logic           found [SLOTS];

	// split the live pins into the driven pin and the rest
	always_comb begin
		for (int i = 0; i < LEVEL_W; i++) begin
			live[i]  = levels[i] && (i < PIN_COUNT);
			other[i] = live[i] && (PIN_W'(i) != pin);
		end
		target_hi = |(live & ~other);
	end

	// peel off the lowest shorted pins one slot at a time
	always_comb begin
		masks[0]   = other;
		cls.count  = '0;
		cls.status = {|other, target_hi};
		for (int k = 0; k < SLOTS; k++) begin
			hit[k]   = lowest_set(masks[k]);
			found[k] = hit[k][PIN_W] && (k < SHORTS_STORED);
			cls.shorts[k] = found[k] ? hit[k][PIN_W-1:0] : '0;
			cls.count     = cls.count + COUNT_W'(found[k]);
			masks[k+1]    = masks[k] & (masks[k] - LEVEL_W'(1));
		end
	end

endmodule

// ===== sv/cable_continuity_scan.sv =====
// ----------------------------------------------------------------------------
// cable_continuity_scan
// Steps a cable continuity test one pin at a time and reports each pin.
// ----------------------------------------------------------------------------
// Takes one request per clock while the output is not stalled: the request is
// registered in the input stage, classified by one pass of parallel logic over
// all receive pins, and the result is registered toward the output.
// A start request clears the pin counter and the cable-broken flag and answers
// with the mux number and channel for pin 0; each sample request classifies
// the driven pin (ok = it reads high, shorted = some other pin reads high),
// lists the lowest shorted pins, and gives the mux settings for the next pin.
// A sample with no test running is dropped without a result. The result for
// the last pin carries done_res and ends the test.
module cable_continuity_scan (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic                                      cmd,
	input  ccs_pkg::level_t                           pin_levels,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output ccs_pkg::pin_t                             tested_pin,
	output logic [ccs_pkg::STATUS_W-1:0]              pin_state,
	output logic [ccs_pkg::COUNT_W-1:0]               short_count,
	output ccs_pkg::pin_t                             short_pin_a,
	output ccs_pkg::pin_t                             short_pin_b,
	output ccs_pkg::pin_t                             short_pin_c,
	output ccs_pkg::pin_t                             short_pin_d,
	output logic [ccs_pkg::MUX_W-1:0]                 mux_number,
	output logic [ccs_pkg::MUX_W-1:0]                 chan_sel,
	output logic                                      done_res,
	output logic                                      cable_broken
);
	import ccs_pkg::*;

	// input stage
	logic   vld_s1;
	logic   cmd_s1;
	level_t lev_s1;

	// test state
	pin_t pin_q;
	logic err_q;
	logic act_q;

	// result register
	logic                        res_vld_q;
	pin_t                        pin_res_q;
	logic [STATUS_W-1:0]         status_q;
	logic [COUNT_W-1:0]          count_q;
	logic [SLOTS-1:0][PIN_W-1:0] shorts_q;
	logic [MUX_W-1:0]            mux_num_q;
	logic [MUX_W-1:0]            mux_ch_q;
	logic                        done_q;
	logic                        broken_q;

	cls_t         cls;
	logic         adv;
	logic         in_acc;
	logic         is_start;
	logic         is_sample;
	logic [PIN_W:0] nxt;
	logic         last;
	logic         err_new;

	ccs_classify u_classify (
		.pin    (pin_q),
		.levels (lev_s1),
		.cls    (cls)
	);

	// handshake: the input stage moves on whenever the result slot frees up
	assign adv       = !res_vld_q || !out_stall;
	assign in_stall  = vld_s1 && !adv;
	assign in_acc    = in_valid && !in_stall;
	assign is_start  = vld_s1 && adv && (cmd_s1 == CMD_START);
	assign is_sample = vld_s1 && adv && (cmd_s1 == CMD_SAMPLE) && act_q;

	// next pin and error update
	assign nxt     = {1'b0, pin_q} + (PIN_W+1)'(1);
	assign last    = nxt >= (PIN_W+1)'(PIN_COUNT);
	assign err_new = err_q || (cls.status != STATUS_OK);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1 <= cmd;
			lev_s1 <= pin_levels;
		end
	end

	// test state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q <= '0;
			err_q <= 1'b0;
			act_q <= 1'b0;
		end else if (is_start) begin
			pin_q <= '0;
			err_q <= 1'b0;
			act_q <= 1'b1;
		end else if (is_sample) begin
			err_q <= err_new;
			if (last) begin
				pin_q <= '0;
				act_q <= 1'b0;
			end else begin
				pin_q <= nxt[PIN_W-1:0];
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (is_start || is_sample) begin
			res_vld_q <= 1'b1;
		end else if (!out_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (is_start) begin
			pin_res_q <= '0;
			status_q  <= '0;
			count_q   <= '0;
			shorts_q  <= '0;
			mux_num_q <= '0;
			mux_ch_q  <= '0;
			done_q    <= 1'b0;
			broken_q  <= 1'b0;
		end else if (is_sample) begin
			pin_res_q <= pin_q;
			status_q  <= cls.status;
			count_q   <= cls.count;
			shorts_q  <= cls.shorts;
			done_q    <= last;
			broken_q  <= err_new;
			if (last) begin
				mux_num_q <= '0;
				mux_ch_q  <= '0;
			end else begin
				mux_num_q <= MUX_W'(nxt / PINS_PER_MUX);
				mux_ch_q  <= MUX_W'(nxt % PINS_PER_MUX);
			end
		end
	end

	// outputs
	assign out_valid    = res_vld_q;
	assign tested_pin   = pin_res_q;
	assign pin_state    = status_q;
	assign short_count  = count_q;
	assign short_pin_a  = shorts_q[0];
	assign short_pin_b  = shorts_q[1];
	assign short_pin_c  = shorts_q[2];
	assign short_pin_d  = shorts_q[3];
	assign mux_number   = mux_num_q;
	assign chan_sel     = mux_ch_q;
	assign done_res     = done_q;
	assign cable_broken = broken_q;

endmodule

// ===== verif/cable_continuity_scan_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cable_continuity_scan_tb
// Self-checking bench for the cable continuity scan block.
// ----------------------------------------------------------------------------
// Drives start and sample requests through the valid/stall input channel and
// predicts every pin report in a small tracker class. Each accepted report is
// compared field by field with the oldest prediction. A directed opening covers
// open, ok, shorted and saturated pins, ignored samples and restarts; full scans
// with random pin levels, aborted scans and stray samples follow. Both sides
// idle in random bursts. One long receiver hold-off backs the block up to its
// input.
module cable_continuity_scan_tb;
	import ccs_pkg::*;

	localparam int TOTAL_REPORTS = 1300;
	localparam int QUIET_TAIL    = 120;
	localparam int HOLD_AT       = 400;
	localparam int HOLD_CYCLES   = 300;
	localparam int STUCK_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 8;

	// one pin report as seen on the output channel
	typedef struct packed {
		pin_t                tested;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
		pin_t                short_a;
		pin_t                short_b;
		pin_t                short_c;
		pin_t                short_d;
		logic [MUX_W-1:0]    mux_num;
		logic [MUX_W-1:0]    mux_chan;
		logic                done;
		logic                broken;
	} pin_report_t;

	// tracks the scan state and the pin reports still owed by the block
	class pin_scan_tracker;
		int          next_pin;
		bit          broken_flag;
		bit          scan_running;
		pin_report_t report_q[$];
		int          errors;
		int          reports_made;

		function new();
			next_pin     = 0;
			broken_flag  = 0;
			scan_running = 0;
			errors       = 0;
			reports_made = 0;
		endfunction

		function int pending();
			return report_q.size();
		endfunction

		// classify one accepted request and queue the report it causes
		function void note_request(logic c, level_t lv);
			pin_report_t r;
			pin_t        slot [SLOTS];
			int          nshort;
			int          nxt;
			r      = '0;
			nshort = 0;
			for (int k = 0; k < SLOTS; k++)
				slot[k] = '0;
			if (c == CMD_START) begin
				next_pin     = 0;
				broken_flag  = 0;
				scan_running = 1;
				report_q.push_back(r);
				reports_made++;
				return;
			end
			if (!scan_running)
				return;
			for (int i = 0; i < PIN_COUNT; i++) begin
				if (lv[i]) begin
					if (i == next_pin) begin
						r.status[0] = 1'b1;
					end else begin
						r.status[1] = 1'b1;
						if (nshort < SHORTS_STORED) begin
							slot[nshort] = pin_t'(i);
							nshort++;
						end
					end
				end
			end
			if (r.status != STATUS_OK)
				broken_flag = 1;
			r.tested  = pin_t'(next_pin);
			r.count   = COUNT_W'(nshort);
			r.short_a = slot[0];
			r.short_b = slot[1];
			r.short_c = slot[2];
			r.short_d = slot[3];
			r.broken  = broken_flag;
			// last pin ends the scan and points the mux back at pin 0
			if (next_pin + 1 >= PIN_COUNT) begin
				r.done       = 1'b1;
				scan_running = 0;
				next_pin     = 0;
			end else begin
				nxt        = next_pin + 1;
				next_pin   = nxt;
				r.mux_num  = MUX_W'(nxt / PINS_PER_MUX);
				r.mux_chan = MUX_W'(nxt % PINS_PER_MUX);
			end
			report_q.push_back(r);
			reports_made++;
		endfunction

		function void check_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		// compare one accepted report with the oldest prediction
		function void check_result(pin_report_t got);
			pin_report_t want;
			if (report_q.size() == 0) begin
				$error("pin report with none pending: tested_pin %0d", got.tested);
				errors++;
				return;
			end
			want = report_q.pop_front();
			check_field("tested_pin", want.tested, got.tested);
			check_field("pin_state", want.status, got.status);
			check_field("short_count", want.count, got.count);
			check_field("short_pin_a", want.short_a, got.short_a);
			check_field("short_pin_b", want.short_b, got.short_b);
			check_field("short_pin_c", want.short_c, got.short_c);
			check_field("short_pin_d", want.short_d, got.short_d);
			check_field("mux_number", want.mux_num, got.mux_num);
			check_field("chan_sel", want.mux_chan, got.mux_chan);
			check_field("done_res", want.done, got.done);
			check_field("cable_broken", want.broken, got.broken);
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                cmd;
	level_t              pin_levels;
	logic                out_valid;
	logic                out_stall;
	pin_t                tested_pin;
	logic [STATUS_W-1:0] pin_state;
	logic [COUNT_W-1:0]  short_count;
	pin_t                short_pin_a;
	pin_t                short_pin_b;
	pin_t                short_pin_c;
	pin_t                short_pin_d;
	logic [MUX_W-1:0]    mux_number;
	logic [MUX_W-1:0]    chan_sel;
	logic                done_res;
	logic                cable_broken;

	pin_scan_tracker tracker = new();

	bit quiet;
	bit hold_req;
	bit hold_used;
	bit holding;
	int unsigned stuck_cycles;

	cable_continuity_scan u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.pin_levels   (pin_levels),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.tested_pin   (tested_pin),
		.pin_state    (pin_state),
		.short_count  (short_count),
		.short_pin_a  (short_pin_a),
		.short_pin_b  (short_pin_b),
		.short_pin_c  (short_pin_c),
		.short_pin_d  (short_pin_d),
		.mux_number   (mux_number),
		.chan_sel     (chan_sel),
		.done_res     (done_res),
		.cable_broken (cable_broken)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// note accepted requests, check accepted reports
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.note_request(cmd, pin_levels);
			if (out_valid && !out_stall)
				tracker.check_result({tested_pin, pin_state, short_count, short_pin_a,
					short_pin_b, short_pin_c, short_pin_d, mux_number, chan_sel,
					done_res, cable_broken});
		end
	end

	// watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off, none near the end
	initial begin
		out_stall = 1'b0;
		holding   = 1'b0;
		hold_used = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_used) begin
				hold_used = 1'b1;
				holding   = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding   = 1'b0;
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// offer one request, with an optional idle burst ahead of it
	task automatic send_req(input logic c, input level_t lv);
		int gap;
		if (!quiet && !holding && !(hold_req && !hold_used) && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		pin_levels <= lv;
		do @(posedge clk); while (in_stall);
	endtask

	// random pin levels, mostly a healthy pin with some faults mixed in
	function automatic level_t rand_levels(int p);
		level_t lv;
		int     pick;
		pick = $urandom_range(0, 99);
		lv   = level_t'(1) << p;
		if (pick < 55) begin
			return lv;
		end else if (pick < 65) begin
			return '0;
		end else if (pick < 80) begin
			if ($urandom_range(0, 3) == 0)
				lv = '0;
			repeat ($urandom_range(1, 5))
				lv[$urandom_range(0, PIN_COUNT - 1)] = 1'b1;
			return lv;
		end else if (pick < 92) begin
			return level_t'({$urandom(), $urandom()});
		end else if (pick < 96) begin
			return '1;
		end
		return ~lv;
	endfunction

	// stimulus
	initial begin
		int kind;
		int stop_at;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		cmd        = CMD_START;
		pin_levels = '0;
		quiet      = 1'b0;
		hold_req   = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: ignored samples, open, ok, shorts, saturation, restart
		send_req(CMD_SAMPLE, '1);
		send_req(CMD_SAMPLE, '0);
		send_req(CMD_START, '1);
		send_req(CMD_SAMPLE, level_t'(1));
		send_req(CMD_SAMPLE, '0);
		send_req(CMD_SAMPLE, '1);
		send_req(CMD_SAMPLE, level_t'(1) << (PIN_COUNT - 1));
		send_req(CMD_SAMPLE, (level_t'(1) << 4) | (level_t'(3) << (PIN_COUNT - 2)));
		send_req(CMD_SAMPLE, level_t'(1) << 5);
		send_req(CMD_START, '0);
		send_req(CMD_SAMPLE, ~level_t'(1));
		send_req(CMD_SAMPLE, level_t'(1) << 1);
		send_req(CMD_START, level_t'({$urandom(), $urandom()}));

		// random: mostly complete scans, some aborted scans and stray requests
		while (tracker.reports_made < TOTAL_REPORTS) begin
			if (tracker.reports_made >= HOLD_AT)
				hold_req = 1'b1;
			if (tracker.reports_made >= TOTAL_REPORTS - QUIET_TAIL)
				quiet = 1'b1;
			kind = $urandom_range(0, 99);
			if (kind < 80) begin
				stop_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, PIN_COUNT - 2)
					: PIN_COUNT - 1;
				send_req(CMD_START, level_t'({$urandom(), $urandom()}));
				for (int p = 0; p <= stop_at; p++)
					send_req(CMD_SAMPLE, rand_levels(p));
			end else if (kind < 90) begin
				repeat ($urandom_range(1, 3))
					send_req(CMD_SAMPLE, level_t'({$urandom(), $urandom()}));
			end else begin
				send_req(CMD_START, '0);
				repeat ($urandom_range(0, 6))
					send_req(CMD_SAMPLE, level_t'({$urandom(), $urandom()}));
			end
		end
		in_valid <= 1'b0;

		// drain outstanding reports, then let the pipeline settle
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.pending() != 0) begin
			$error("%0d pin reports never arrived", tracker.pending());
			tracker.errors++;
		end
		if (tracker.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
